// ----- design/rahm_pkg.sv -----
// Package for the request/acknowledge link master.
// Types, codes and link constants shared by all design modules; no dependencies.

package rahm_pkg;

    localparam int unsigned CNT_W     = 26;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NIB_W     = 4;
    localparam int unsigned STATUS_W  = 9;
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [CNT_W-1:0]  TIMEOUT_RESET = CNT_W'(50000000);
    localparam logic [BYTE_W-1:0] LINK_REQ      = 8'h10;
    localparam logic [BYTE_W-1:0] ECHO_BASE     = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h00;

    typedef enum logic [1:0] {
        KIND_CMD_WRITE  = 2'd0,
        KIND_BYTE_WRITE = 2'd1,
        KIND_DATA_READ  = 2'd2,
        KIND_STATUS     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RES_OK            = 2'd0,
        RES_ACK_TIMEOUT   = 2'd1,
        RES_ECHO_MISMATCH = 2'd2,
        RES_REL_TIMEOUT   = 2'd3
    } t_result;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ACK  = 3'b010,
        PH_REL  = 3'b100
    } t_phase;

    typedef struct packed {
        t_kind                kind;
        logic [BYTE_W-1:0]    data_value;
        logic [STATUS_W-1:0]  pic_status;
    } t_in_item;

    typedef struct packed {
        logic                 command_write;
        logic [BYTE_W-1:0]    command_value;
        logic                 done_res;
        t_result              result_code;
        logic [BYTE_W-1:0]    read_data;
        logic                 busy_res;
    } t_out_item;

endpackage

// ----- design/rahm_in_slice.sv -----
// Input register stage of the link master.
// Holds one accepted transfer until the core consumes it; uses rahm_pkg.

module rahm_in_slice
    import rahm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_take,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign n_valid = i_valid || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- design/rahm_core.sv -----
// Transaction state and per-item step logic of the link master.
// Holds the ack timeout register; uses rahm_pkg.

module rahm_core
    import rahm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    input  logic             i_fire,
    input  t_in_item         i_item,
    output t_out_item        o_result
);

    logic [CNT_W-1:0]  r_ack_timeout;
    t_phase            r_phase,    n_phase;
    t_kind             r_txn,      n_txn;
    logic [BYTE_W-1:0] r_expected, n_expected;
    logic [NIB_W-1:0]  r_pending,  n_pending;
    logic              r_second,   n_second;
    logic [CNT_W-1:0]  r_cnt,      n_cnt;
    logic [BYTE_W-1:0] r_latched,  n_latched;

    logic              ack;
    logic [BYTE_W-1:0] echo;
    logic [CNT_W-1:0]  cnt_inc;
    logic              timed_out;
    logic              cw;
    logic [BYTE_W-1:0] cv;
    logic              done;
    t_result           code;

    assign ack       = i_item.pic_status[STATUS_W-1];
    assign echo      = i_item.pic_status[BYTE_W-1:0];
    assign cnt_inc   = r_cnt + 1'b1;
    assign timed_out = (cnt_inc >= r_ack_timeout);

    always_comb begin
        n_phase    = r_phase;
        n_txn      = r_txn;
        n_expected = r_expected;
        n_pending  = r_pending;
        n_second   = r_second;
        n_cnt      = r_cnt;
        n_latched  = r_latched;
        cw         = 1'b0;
        cv         = CMD_CLEAR;
        done       = 1'b0;
        code       = RES_OK;
        case (r_phase)
            PH_IDLE: begin
                case (i_item.kind)
                    KIND_CMD_WRITE, KIND_BYTE_WRITE: begin
                        n_txn      = i_item.kind;
                        n_second   = 1'b0;
                        n_expected = ECHO_BASE | {4'h0, i_item.data_value[NIB_W-1:0]};
                        n_cnt      = '0;
                        n_phase    = PH_ACK;
                        cw         = 1'b1;
                        cv         = ECHO_BASE | LINK_REQ
                                     | {4'h0, i_item.data_value[NIB_W-1:0]};
                        if (i_item.kind == KIND_BYTE_WRITE) begin
                            n_pending = i_item.data_value[BYTE_W-1:NIB_W];
                        end
                    end
                    KIND_DATA_READ: begin
                        n_txn    = KIND_DATA_READ;
                        n_second = 1'b0;
                        n_cnt    = '0;
                        n_phase  = PH_ACK;
                        cw       = 1'b1;
                        cv       = LINK_REQ;
                    end
                    default: ;
                endcase
            end
            PH_ACK: begin
                if (i_item.kind == KIND_STATUS) begin
                    n_cnt = cnt_inc;
                    if (ack) begin
                        cw = 1'b1;
                        if (r_txn == KIND_DATA_READ) begin
                            n_latched = echo;
                            n_cnt     = '0;
                            n_phase   = PH_REL;
                        end else if (echo != r_expected) begin
                            done    = 1'b1;
                            code    = RES_ECHO_MISMATCH;
                            n_phase = PH_IDLE;
                        end else begin
                            n_cnt   = '0;
                            n_phase = PH_REL;
                        end
                    end else if (timed_out) begin
                        cw      = 1'b1;
                        done    = 1'b1;
                        code    = RES_ACK_TIMEOUT;
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_REL: begin
                if (i_item.kind == KIND_STATUS) begin
                    n_cnt = cnt_inc;
                    if (!ack) begin
                        if (r_txn == KIND_BYTE_WRITE && !r_second) begin
                            // low nibble released, send the high nibble
                            n_second   = 1'b1;
                            n_expected = ECHO_BASE | {4'h0, r_pending};
                            n_cnt      = '0;
                            n_phase    = PH_ACK;
                            cw         = 1'b1;
                            cv         = ECHO_BASE | LINK_REQ | {4'h0, r_pending};
                        end else begin
                            done    = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end else if (timed_out) begin
                        done    = 1'b1;
                        code    = RES_REL_TIMEOUT;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_ack_timeout <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_txn      <= KIND_CMD_WRITE;
            r_expected <= '0;
            r_pending  <= '0;
            r_second   <= 1'b0;
            r_cnt      <= '0;
            r_latched  <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_txn      <= n_txn;
            r_expected <= n_expected;
            r_pending  <= n_pending;
            r_second   <= n_second;
            r_cnt      <= n_cnt;
            r_latched  <= n_latched;
        end
    end

    always_comb begin
        o_result.command_write = cw;
        o_result.command_value = cv;
        o_result.done_res      = done;
        o_result.result_code   = code;
        o_result.read_data     = n_latched;
        o_result.busy_res      = (n_phase != PH_IDLE);
    end

endmodule

// ----- design/rahm_out_reg.sv -----
// Result register stage of the link master.
// Holds one result transfer while the receiver stalls; uses rahm_pkg.

module rahm_out_reg
    import rahm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_out_item i_result,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_result
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_result;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = i_valid || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- design/req_ack_handshake_master_unit.sv -----
// Top level of the request/acknowledge link master.
// Instantiates rahm_in_slice, rahm_core and rahm_out_reg; uses rahm_pkg.
//
// Usage:
//   Slave stream carries one item per transfer: tuser is the kind (command
//   write, byte write, data read, status sample), tdata the byte and the
//   sampled link status. Every accepted item yields exactly one result
//   transfer on the master stream: command write strobe and value, done
//   strobe and result code, last read byte and busy flag.
//   The ack timeout register is written through i_cfg_wr_en/i_cfg_wr_data;
//   the user must write it only while the block is idle, as the block itself does not enforce this.
//   Result valid follows the input transfer through the input register, then
//   the step logic into the result register.
//   Throughput is one item per cycle while the receiver does not stall; the
//   single state update per item in the core sets that figure.
//   Reset clears both stage valids, the transaction state and sets the
//   timeout to 50000000 samples.
//   When the receiver stalls, the result register holds, the input register
//   fills with one more item, and tready then drops until the result drains.

module req_ack_handshake_master_unit
    import rahm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CNT_W-1:0]     i_cfg_wr_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [7:0] data_value, [16:8] pic_status, [23:17] zero
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [0] command_write, [8:1] command_value, [9] done_res,
    // [11:10] result_code, [19:12] read_data, [20] busy_res, [23:21] zero
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    t_in_item  in_item;
    t_in_item  core_item;
    t_out_item core_result;
    t_out_item out_result;
    logic      core_valid;
    logic      out_ready;
    logic      core_fire;

    always_comb begin
        in_item.kind       = t_kind'(i_s_axis_tuser);
        in_item.data_value = i_s_axis_tdata[BYTE_W-1:0];
        in_item.pic_status = i_s_axis_tdata[BYTE_W+STATUS_W-1:BYTE_W];
    end

    assign core_fire = core_valid && out_ready;

    rahm_in_slice u_in_slice (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (core_valid),
        .i_take  (core_fire),
        .o_item  (core_item)
    );

    rahm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (core_fire),
        .i_item        (core_item),
        .o_result      (core_result)
    );

    rahm_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (core_valid),
        .o_ready  (out_ready),
        .i_result (core_result),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = {3'b000,
                             out_result.busy_res,
                             out_result.read_data,
                             out_result.result_code,
                             out_result.done_res,
                             out_result.command_value,
                             out_result.command_write};

endmodule

// ----- design/rahm_checker.sv -----
// Port-level checks for the request/acknowledge link master.
// Bound to req_ack_handshake_master_unit; uses rahm_pkg.

module rahm_checker
    import rahm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // a finished transaction leaves the master idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[9] |-> !o_m_axis_tdata[20])
        else $error("done with busy set");

    // result code only meaningful with done
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[9] |-> o_m_axis_tdata[11:10] == 2'd0)
        else $error("result code without done");

    // no command value without a write strobe
    a_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[8:1] == 8'h00)
        else $error("command value without write");

    // a command write with a request bit set starts a transaction
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] && o_m_axis_tdata[5] |->
            o_m_axis_tdata[20])
        else $error("request driven while idle");

endmodule

bind req_ack_handshake_master_unit rahm_checker u_rahm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ----- sim/tb_top.sv -----
// Testbench for req_ack_handshake_master_unit: command writes, byte writes, data reads
// and status samples are streamed in and every result is checked against a local predictor.
// Depends on rahm_pkg and the design sources only.
`timescale 1ns / 100ps

module tb_top;
    import rahm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_AT       = 1000;
    localparam int STALL_CYCLES   = 300;
    localparam int STEADY_FROM    = 1200;
    localparam int STEADY_TO      = 1500;
    localparam logic [CNT_W-1:0] LIMIT_MAX = '1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    req_ack_handshake_master_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // link state as the block should hold it
    t_phase           link_ph    = PH_IDLE;
    t_kind            link_kind  = KIND_CMD_WRITE;
    logic [7:0]       echo_want  = '0;
    logic [3:0]       hi_nib     = '0;
    logic             hi_sent    = 1'b0;
    logic [CNT_W-1:0] sample_cnt = '0;
    logic [CNT_W-1:0] ack_limit  = TIMEOUT_RESET;
    logic [7:0]       read_byte  = '0;

    t_in_item  send_q[$];
    t_out_item link_results_q[$];
    t_in_item  cur_item;
    t_out_item want_res;

    int queued_items = 0;
    int items_in     = 0;
    int results_seen = 0;
    int errors       = 0;
    int stuck        = 0;
    int stall_left   = 0;
    bit stall_done   = 1'b0;
    int code_seen[4] = '{0, 0, 0, 0};

    function automatic t_out_item link_step(input t_in_item it);
        t_out_item r;
        logic      ack;
        r = '0;
        ack = it.pic_status[8];
        if (link_ph == PH_IDLE) begin
            if (it.kind != KIND_STATUS) begin
                link_kind = it.kind;
                hi_sent = 1'b0;
                sample_cnt = '0;
                link_ph = PH_ACK;
                r.command_write = 1'b1;
                if (it.kind == KIND_DATA_READ) begin
                    r.command_value = LINK_REQ;
                end else begin
                    if (it.kind == KIND_BYTE_WRITE) begin
                        hi_nib = it.data_value[7:4];
                    end
                    echo_want = ECHO_BASE | {4'h0, it.data_value[3:0]};
                    r.command_value = echo_want | LINK_REQ;
                end
            end
        end else if (it.kind == KIND_STATUS) begin
            sample_cnt = sample_cnt + 1'b1;
            if (link_ph == PH_ACK) begin
                if (ack) begin
                    r.command_write = 1'b1;
                    r.command_value = CMD_CLEAR;
                    if (link_kind == KIND_DATA_READ) begin
                        read_byte = it.pic_status[7:0];
                        sample_cnt = '0;
                        link_ph = PH_REL;
                    end else if (it.pic_status[7:0] != echo_want) begin
                        r.done_res = 1'b1;
                        r.result_code = RES_ECHO_MISMATCH;
                        link_ph = PH_IDLE;
                    end else begin
                        sample_cnt = '0;
                        link_ph = PH_REL;
                    end
                end else if (sample_cnt >= ack_limit) begin
                    r.command_write = 1'b1;
                    r.command_value = CMD_CLEAR;
                    r.done_res = 1'b1;
                    r.result_code = RES_ACK_TIMEOUT;
                    link_ph = PH_IDLE;
                end
            end else begin
                if (!ack) begin
                    if (link_kind == KIND_BYTE_WRITE && !hi_sent) begin
                        hi_sent = 1'b1;
                        echo_want = ECHO_BASE | {4'h0, hi_nib};
                        sample_cnt = '0;
                        link_ph = PH_ACK;
                        r.command_write = 1'b1;
                        r.command_value = echo_want | LINK_REQ;
                    end else begin
                        r.done_res = 1'b1;
                        r.result_code = RES_OK;
                        link_ph = PH_IDLE;
                    end
                end else if (sample_cnt >= ack_limit) begin
                    r.done_res = 1'b1;
                    r.result_code = RES_REL_TIMEOUT;
                    link_ph = PH_IDLE;
                end
            end
        end
        r.read_data = read_byte;
        r.busy_res = (link_ph != PH_IDLE);
        return r;
    endfunction

    task automatic push_item(input t_kind k, input logic [7:0] dv, input logic [8:0] st);
        t_in_item it;
        it.kind = k;
        it.data_value = dv;
        it.pic_status = st;
        send_q.push_back(it);
        queued_items++;
    endtask

    task automatic sample(input logic ack, input logic [7:0] b);
        push_item(KIND_STATUS, 8'($urandom_range(0, 255)), {ack, b});
    endtask

    // one wait for ack, then one wait for release
    task automatic handshake(input logic [7:0] echo, input bit bad_echo);
        int wait_max;
        wait_max = ($urandom_range(0, 7) == 0) ? 12 : 3;
        repeat ($urandom_range(0, wait_max)) sample(1'b0, 8'($urandom_range(0, 255)));
        if (bad_echo) begin
            sample(1'b1, echo ^ (8'h01 << $urandom_range(0, 7)));
        end else begin
            sample(1'b1, echo);
        end
        repeat ($urandom_range(0, wait_max)) sample(1'b1, 8'($urandom_range(0, 255)));
        sample(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_txn();
        int         pick;
        logic [7:0] v;
        bit         bad;
        pick = $urandom_range(0, 9);
        v = 8'($urandom_range(0, 255));
        bad = ($urandom_range(0, 7) == 0);
        if (pick < 2) begin
            repeat ($urandom_range(1, 3)) begin
                push_item(t_kind'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                          9'($urandom_range(0, 511)));
            end
        end else if (pick < 4) begin
            push_item(KIND_CMD_WRITE, v, 9'($urandom_range(0, 511)));
            handshake(ECHO_BASE | {4'h0, v[3:0]}, bad);
        end else if (pick < 7) begin
            push_item(KIND_BYTE_WRITE, v, 9'($urandom_range(0, 511)));
            handshake(ECHO_BASE | {4'h0, v[3:0]}, bad);
            if (!bad) begin
                handshake(ECHO_BASE | {4'h0, v[7:4]}, $urandom_range(0, 7) == 0);
            end
        end else begin
            push_item(KIND_DATA_READ, v, 9'($urandom_range(0, 511)));
            handshake(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic run_random(input int n);
        int stop_at;
        stop_at = queued_items + n;
        while (queued_items < stop_at) random_txn();
    endtask

    task automatic drain();
        while (!(send_q.size() == 0 && !s_tvalid && link_results_q.size() == 0)) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] v);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        ack_limit = v;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                link_results_q.push_back(link_step(cur_item));
                items_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_q.size() != 0 && ((items_in >= STEADY_FROM && items_in < STEADY_TO)
                        || $urandom_range(0, 99) >= 32)) begin
                    cur_item = send_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, cur_item.pic_status, cur_item.data_value};
                    s_tuser <= cur_item.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tdata[9]) begin
                    code_seen[m_tdata[11:10]]++;
                end
                if (link_results_q.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    want_res = link_results_q.pop_front();
                    check_field("command_write", 32'(want_res.command_write),
                                32'(m_tdata[0]));
                    check_field("command_value", 32'(want_res.command_value),
                                32'(m_tdata[8:1]));
                    check_field("done_res", 32'(want_res.done_res), 32'(m_tdata[9]));
                    check_field("result_code", 32'(want_res.result_code),
                                32'(m_tdata[11:10]));
                    check_field("read_data", 32'(want_res.read_data), 32'(m_tdata[19:12]));
                    check_field("busy_res", 32'(want_res.busy_res), 32'(m_tdata[20]));
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if (!stall_done && results_seen >= STALL_AT) begin
                stall_done <= 1'b1;
                stall_left <= STALL_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (results_seen >= STEADY_FROM && results_seen < STEADY_TO)
                            || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck <= 0;
        end else if (stuck >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: nibble extremes, byte write, mismatch, read, starts while busy
        push_item(KIND_CMD_WRITE, 8'h00, 9'h000);
        sample(1'b1, 8'h80);
        sample(1'b0, 8'h00);
        push_item(KIND_CMD_WRITE, 8'hff, 9'h1ff);
        sample(1'b0, 8'hff);
        sample(1'b1, 8'h8f);
        sample(1'b1, 8'h00);
        sample(1'b0, 8'hff);
        push_item(KIND_BYTE_WRITE, 8'ha5, 9'h155);
        sample(1'b1, 8'h85);
        sample(1'b0, 8'h5a);
        sample(1'b1, 8'h8a);
        sample(1'b0, 8'ha5);
        push_item(KIND_BYTE_WRITE, 8'h3c, 9'h0aa);
        sample(1'b1, 8'h00);
        push_item(KIND_DATA_READ, 8'h5a, 9'h000);
        sample(1'b1, 8'hff);
        sample(1'b0, 8'h00);
        push_item(KIND_DATA_READ, 8'h00, 9'h1ff);
        push_item(KIND_CMD_WRITE, 8'h07, 9'h100);
        sample(1'b1, 8'h00);
        push_item(KIND_BYTE_WRITE, 8'hff, 9'h000);
        sample(1'b0, 8'h7e);
        sample(1'b1, 8'hff);
        run_random(400);
        drain();

        // read left waiting for ack, then the limit drops to zero
        push_item(KIND_DATA_READ, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
        sample(1'b0, 8'($urandom_range(0, 255)));
        drain();
        write_limit('0);
        sample(1'b0, 8'($urandom_range(0, 255)));
        run_random(400);
        drain();

        write_limit(LIMIT_MAX);
        run_random(450);
        drain();

        // command write left waiting for release, then the limit drops
        push_item(KIND_CMD_WRITE, 8'h06, 9'($urandom_range(0, 511)));
        sample(1'b1, 8'h86);
        drain();
        write_limit(CNT_W'($urandom_range(2, 6)));
        sample(1'b1, 8'($urandom_range(0, 255)));
        run_random(400);
        drain();

        write_limit(CNT_W'(1));
        run_random(300);
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items / %0d results over five ack timeout settings", items_in,
                 results_seen);
        $display("Done codes ok %0d, ack timeout %0d, echo mismatch %0d, release timeout %0d",
                 code_seen[0], code_seen[1], code_seen[2], code_seen[3]);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/rahm_pkg.sv
design/rahm_in_slice.sv
design/rahm_core.sv
design/rahm_out_reg.sv
design/req_ack_handshake_master_unit.sv
design/rahm_checker.sv
sim/tb_top.sv
